// ===== design/tsa_pkg.sv =====
// Shared types and constants of the two-axis spike limiter and ring averager.
package tsa_pkg;

	localparam int DATA_W = 16;

	localparam logic [DATA_W-1:0] RESET_LEVEL = 16'd512;
	localparam logic [DATA_W-1:0] VALID_MAX_RESET = 16'd1023;
	localparam logic [DATA_W-1:0] JUMP_THR_RESET = 16'd100;

	localparam logic CFG_VALID_MAX = 1'b0;
	localparam logic CFG_JUMP_THR = 1'b1;

	localparam logic OP_LIMIT = 1'b0;
	localparam logic OP_AVERAGE = 1'b1;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LCMP,
		S_LDIFF,
		S_LNEG,
		S_LTHR,
		S_LPULL,
		S_AWRITE,
		S_ASUM,
		S_ALAST,
		S_ADIV,
		S_OUT
	} tsa_state_t;

endpackage

// ===== design/tsa_if.sv =====
// Valid/ready channel interfaces for the sample input and the filtered output.
interface tsa_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic        axis_select;
	logic [15:0] sample;

	modport source (output valid, output operation, output axis_select, output sample,
		input ready);
	modport sink (input valid, input operation, input axis_select, input sample,
		output ready);
endinterface

interface tsa_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] filtered;

	modport source (output valid, output filtered, input ready);
	modport sink (input valid, input filtered, output ready);
endinterface

// ===== design/two_axis_spike_limit_and_average.sv =====
// Top level of the two-axis spike limiter and ring averager.
//
// Channel     Dir  Payload                          Handshake
// sample_ch   in   operation, axis_select, sample   valid/ready
// result_ch   out  filtered                         valid/ready
// cfg         in   cfg_index, cfg_data              cfg_we, no wait
//
// Spike limiting and the ring average run as a sequence of states from accept to the
// result register, because one shared adder does every compare and one ring entry
// is read and summed per cycle from the ring memory, which has separate write and read ports.
// The mean is then formed by one reciprocal multiply. One word is in work at a time.
// After reset all ring entries read as 512 through valid bits; no clearing pass.
// A finished word waits in the output register while the next word is accepted.
module two_axis_spike_limit_and_average import tsa_pkg::*; #(
	parameter int RING_LENGTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	tsa_in_if.sink            sample_ch,
	tsa_out_if.source         result_ch
);

	localparam int IDX_W = $clog2(RING_LENGTH);
	localparam int DEPTH = 2 * RING_LENGTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SUM_W = DATA_W + IDX_W;
	localparam int M_W = SUM_W + 2;
	localparam int PROD_W = SUM_W + M_W;
	localparam int SHIFT = SUM_W + IDX_W;
	localparam logic [M_W-1:0] RECIP_M = M_W'(((64'd1 << SHIFT) + 64'(RING_LENGTH) - 64'd1)
		/ 64'(RING_LENGTH));
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_LENGTH - 1);
	localparam logic [ADDR_W-1:0] Y_BASE = ADDR_W'(RING_LENGTH);

	tsa_state_t state_q, state_d;

	logic [DATA_W-1:0] valid_max_q, jump_thr_q;
	logic [DATA_W-1:0] last_good_q [2];
	logic [IDX_W-1:0]  pos_q [2];

	logic              axis_q, above_q;
	logic [DATA_W-1:0] smp_q, diff_q, res_q;
	logic [SUM_W-1:0]  acc_q;
	logic [IDX_W-1:0]  idx_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;

	alu_op_t           alu_op;
	logic [SUM_W-1:0]  alu_a, alu_b, alu_y;
	logic              alu_borrow;

	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [DATA_W-1:0] rd_data, prev;
	logic [PROD_W-1:0] prod;
	logic              in_acc, out_free;

	assign in_acc = sample_ch.valid && sample_ch.ready;
	assign out_free = !out_valid_q || result_ch.ready;
	assign prev = last_good_q[axis_q];
	assign sample_ch.ready = (state_q == S_IDLE);
	assign result_ch.valid = out_valid_q;
	assign result_ch.filtered = out_data_q;

	tsa_alu #(.W(SUM_W)) u_alu (
		.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y), .borrow(alu_borrow)
	);

	tsa_ring #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ring (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(smp_q),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	assign prod = {{M_W{1'b0}}, acc_q} * {{SUM_W{1'b0}}, RECIP_M};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_acc) state_d = (sample_ch.operation == OP_AVERAGE) ? S_AWRITE : S_LCMP;
			S_LCMP:   state_d = alu_borrow ? S_OUT : S_LDIFF;
			S_LDIFF:  state_d = alu_borrow ? S_LNEG : S_LTHR;
			S_LNEG:   state_d = S_LTHR;
			S_LTHR:   state_d = alu_borrow ? S_LPULL : S_OUT;
			S_LPULL:  state_d = S_OUT;
			S_AWRITE: state_d = S_ASUM;
			S_ASUM:   if (idx_q == LAST_IDX) state_d = S_ALAST;
			S_ALAST:  state_d = S_ADIV;
			S_ADIV:   state_d = S_OUT;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		alu_op = ALU_SUB;
		alu_a = '0;
		alu_b = '0;
		wr_en = 1'b0;
		rd_en = 1'b0;
		wr_addr = axis_q ? Y_BASE + ADDR_W'(pos_q[1]) : ADDR_W'(pos_q[0]);
		rd_addr = axis_q ? Y_BASE + ADDR_W'(idx_q) : ADDR_W'(idx_q);
		unique case (state_q)
			S_LCMP: begin
				alu_a = SUM_W'(valid_max_q);
				alu_b = SUM_W'(smp_q);
			end
			S_LDIFF: begin
				alu_a = SUM_W'(smp_q);
				alu_b = SUM_W'(prev);
			end
			S_LNEG: begin
				alu_a = SUM_W'(prev);
				alu_b = SUM_W'(smp_q);
			end
			S_LTHR: begin
				alu_a = SUM_W'(jump_thr_q);
				alu_b = SUM_W'(diff_q);
			end
			S_LPULL: begin
				alu_op = above_q ? ALU_ADD : ALU_SUB;
				alu_a = SUM_W'(prev);
				alu_b = SUM_W'(diff_q >> 2);
			end
			S_AWRITE: wr_en = 1'b1;
			S_ASUM: begin
				rd_en = 1'b1;
				alu_op = ALU_ADD;
				alu_a = acc_q;
				alu_b = SUM_W'(rd_data);
			end
			S_ALAST: begin
				alu_op = ALU_ADD;
				alu_a = acc_q;
				alu_b = SUM_W'(rd_data);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			valid_max_q <= VALID_MAX_RESET;
			jump_thr_q <= JUMP_THR_RESET;
			for (int i = 0; i < 2; i++) begin
				last_good_q[i] <= RESET_LEVEL;
				pos_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_VALID_MAX: valid_max_q <= cfg_data;
					CFG_JUMP_THR:  jump_thr_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_LTHR && !alu_borrow) begin
				last_good_q[axis_q] <= smp_q;
			end
			if (state_q == S_LPULL) begin
				last_good_q[axis_q] <= alu_y[DATA_W-1:0];
			end
			if (state_q == S_AWRITE) begin
				pos_q[axis_q] <= (pos_q[axis_q] == LAST_IDX) ? '0 : pos_q[axis_q] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				axis_q <= sample_ch.axis_select;
				smp_q <= sample_ch.sample;
			end
			S_LCMP:  res_q <= prev;
			S_LDIFF: begin
				diff_q <= alu_y[DATA_W-1:0];
				above_q <= !alu_borrow;
			end
			S_LNEG:  diff_q <= alu_y[DATA_W-1:0];
			S_LTHR:  res_q <= smp_q;
			S_LPULL: res_q <= alu_y[DATA_W-1:0];
			S_AWRITE: begin
				acc_q <= '0;
				idx_q <= '0;
			end
			S_ASUM: begin
				if (idx_q != '0) acc_q <= alu_y;
				if (idx_q != LAST_IDX) idx_q <= idx_q + 1'b1;
			end
			S_ALAST: acc_q <= alu_y;
			S_ADIV:  res_q <= prod[SHIFT +: DATA_W];
			S_OUT:   if (out_free) out_data_q <= res_q;
			default: ;
		endcase
	end

endmodule

// ===== design/tsa_alu.sv =====
// Shared adder and subtractor with borrow, used for every compare and sum.
module tsa_alu import tsa_pkg::*; #(
	parameter int W = 19
) (
	input  alu_op_t      op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] y,
	output logic         borrow
);

	logic [W:0] ext;

	always_comb begin
		unique case (op)
			ALU_ADD: ext = {1'b0, a} + {1'b0, b};
			ALU_SUB: ext = {1'b0, a} - {1'b0, b};
			default: ext = '0;
		endcase
	end

	assign y = ext[W-1:0];
	assign borrow = (op == ALU_SUB) ? ext[W] : 1'b0;

endmodule

// ===== design/tsa_ring.sv =====
// Ring sample memory for both axes, with per-entry valid bits standing in for reset.
module tsa_ring import tsa_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  ok_q;
	logic [DATA_W-1:0] rdata_s1;
	logic              ent_ok_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
			ent_ok_s1 <= ok_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= '0;
		end else if (wr_en) begin
			ok_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = ent_ok_s1 ? rdata_s1 : RESET_LEVEL;

endmodule

// ===== design/tsa_checker.sv =====
// Port-level checker for the two-axis spike limiter and ring averager, with its bind.
module tsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word dropped or changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input taken again before the word was processed");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a word in work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> !(in_ready && $past(!in_ready) && $changed(out_data)))
		else $error("pending result overwritten by the next word");

endmodule

bind two_axis_spike_limit_and_average tsa_checker u_tsa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(sample_ch.valid),
	.in_ready(sample_ch.ready),
	.out_valid(result_ch.valid),
	.out_ready(result_ch.ready),
	.out_data(result_ch.filtered)
);

// ===== tb/two_axis_spike_limit_and_average_tb.sv =====
// Self-checking testbench for the two-axis spike limiter and ring averager.
`timescale 1ns / 100ps

module two_axis_spike_limit_and_average_tb import tsa_pkg::*; ;

	localparam int RING_LEN = 8;
	localparam int SETTLE_CYCLES = RING_LEN + 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AFTER_WORDS = 200;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic              operation;
		logic              axis_select;
		logic [DATA_W-1:0] sample;
	} sample_word_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [DATA_W-1:0] cfg_data;

	tsa_in_if  sample_ch();
	tsa_out_if result_ch();

	two_axis_spike_limit_and_average #(.RING_LENGTH(RING_LEN)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	// Predicted state and configuration of the block.
	logic [DATA_W-1:0] pred_valid_max;
	logic [DATA_W-1:0] pred_jump_thr;
	logic [DATA_W-1:0] pred_last_good [2];
	logic [DATA_W-1:0] pred_ring [2][RING_LEN];
	int                pred_ring_pos [2];

	sample_word_t      pending_words[$];
	logic [DATA_W-1:0] expected_filtered[$];

	int   queued_count = 0;
	int   accepted_count = 0;
	int   result_count = 0;
	int   error_count = 0;
	int   cycle_count = 0;
	logic in_fire = 1'b0;
	logic quiet = 1'b0;
	logic hold_active = 1'b0;
	int   src_gap = 0;
	int   sink_gap = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [DATA_W-1:0] predict_filtered(logic op, logic axis,
			logic [DATA_W-1:0] smp);
		logic [DATA_W-1:0] prev;
		logic [DATA_W-1:0] diff;
		logic [DATA_W-1:0] value;
		int                sum;
		if (op == OP_LIMIT) begin
			prev = pred_last_good[axis];
			if (smp > pred_valid_max)
				return prev;
			diff = (smp > prev) ? smp - prev : prev - smp;
			value = smp;
			if (diff > pred_jump_thr)
				value = (smp > prev) ? prev + (diff >> 2) : prev - (diff >> 2);
			pred_last_good[axis] = value;
			return value;
		end
		pred_ring[axis][pred_ring_pos[axis]] = smp;
		pred_ring_pos[axis] = (pred_ring_pos[axis] + 1) % RING_LEN;
		sum = 0;
		for (int i = 0; i < RING_LEN; i++)
			sum += pred_ring[axis][i];
		return DATA_W'(sum / RING_LEN);
	endfunction

	task automatic note_failure(string msg);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Checks finished words against predictions and predicts each accepted word.
	always @(posedge clk) begin
		logic [DATA_W-1:0] want;
		logic [DATA_W-1:0] next_want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_filtered.size() == 0) begin
					note_failure($sformatf("unexpected result word filtered=%0d",
						result_ch.filtered));
				end else begin
					want = expected_filtered.pop_front();
					if (result_ch.filtered !== want)
						note_failure($sformatf("filtered mismatch: expected %0d, got %0d",
							want, result_ch.filtered));
				end
				result_count <= result_count + 1;
			end
			if (sample_ch.valid && sample_ch.ready) begin
				next_want = predict_filtered(sample_ch.operation, sample_ch.axis_select,
					sample_ch.sample);
				expected_filtered.push_back(next_want);
				accepted_count <= accepted_count + 1;
			end
		end
		in_fire <= arst_n && sample_ch.valid && sample_ch.ready;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Sample driver.
	always @(negedge clk) begin
		sample_word_t w;
		if (arst_n && (!sample_ch.valid || in_fire)) begin
			if (src_gap > 0) begin
				src_gap--;
				sample_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				src_gap = $urandom_range(0, 9);
				sample_ch.valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				w = pending_words.pop_front();
				sample_ch.operation <= w.operation;
				sample_ch.axis_select <= w.axis_select;
				sample_ch.sample <= w.sample;
				sample_ch.valid <= 1'b1;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// One long receiver hold-off so that the block backs up into its input.
	always @(negedge clk) begin
		int   hold_left;
		logic hold_done;
		if (!arst_n) begin
			hold_left = 0;
			hold_done = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			hold_active <= (hold_left > 0);
		end else if (!hold_done && result_count >= HOLD_AFTER_WORDS) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			hold_active <= 1'b1;
		end
	end

	// Result receiver.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_active) begin
				result_ch.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				result_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				sink_gap = $urandom_range(0, 9);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic queue_word(logic op, logic axis, logic [DATA_W-1:0] smp);
		sample_word_t w;
		w.operation = op;
		w.axis_select = axis;
		w.sample = smp;
		pending_words.push_back(w);
		queued_count++;
	endtask

	task automatic wait_drained();
		while (accepted_count != queued_count || result_count != accepted_count)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(logic [DATA_W-1:0] vmax, logic [DATA_W-1:0] thr, int n,
			logic calm);
		int v;
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= CFG_VALID_MAX;
		cfg_data <= vmax;
		@(negedge clk);
		cfg_index <= CFG_JUMP_THR;
		cfg_data <= thr;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= DATA_W'($urandom());
		pred_valid_max = vmax;
		pred_jump_thr = thr;
		@(posedge clk);
		quiet = calm;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: v = $urandom_range(0, 65535);
				1: v = int'(vmax) + $urandom_range(0, 4) - 2;
				2, 3: v = $urandom_range(0, vmax);
				4: v = 512 + $urandom_range(0, 2 * int'(thr) + 8) - int'(thr) - 4;
				default: v = $urandom_range(0, 1) ? 65535 : 0;
			endcase
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			queue_word($urandom_range(0, 1) ? OP_AVERAGE : OP_LIMIT, 1'($urandom_range(0, 1)),
				DATA_W'(v));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_VALID_MAX;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.operation = OP_LIMIT;
		sample_ch.axis_select = 1'b0;
		sample_ch.sample = '0;
		result_ch.ready = 1'b0;
		pred_valid_max = VALID_MAX_RESET;
		pred_jump_thr = JUMP_THR_RESET;
		for (int a = 0; a < 2; a++) begin
			pred_last_good[a] = RESET_LEVEL;
			pred_ring_pos[a] = 0;
			for (int i = 0; i < RING_LEN; i++)
				pred_ring[a][i] = RESET_LEVEL;
		end
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: small steps, a step equal to the threshold, large jumps
		// both ways, samples at and beyond the maximum, and ring wrap-around.
		queue_word(OP_LIMIT, 1'b0, 16'd512);
		queue_word(OP_LIMIT, 1'b0, 16'd612);
		queue_word(OP_LIMIT, 1'b0, 16'd1023);
		queue_word(OP_LIMIT, 1'b0, 16'd1024);
		queue_word(OP_LIMIT, 1'b0, 16'hFFFF);
		queue_word(OP_LIMIT, 1'b0, 16'd0);
		queue_word(OP_LIMIT, 1'b1, 16'd0);
		queue_word(OP_LIMIT, 1'b1, 16'd484);
		queue_word(OP_AVERAGE, 1'b0, 16'hFFFF);
		queue_word(OP_AVERAGE, 1'b0, 16'd0);
		for (int i = 0; i < RING_LEN + 1; i++)
			queue_word(OP_AVERAGE, 1'b1, 16'hFFFF);
		queue_word(OP_LIMIT, 1'b1, 16'hFFFF);

		run_phase(VALID_MAX_RESET, JUMP_THR_RESET, 150, 1'b0);
		run_phase(16'hFFFF, 16'd0, 150, 1'b0);
		run_phase(16'd0, 16'hFFFF, 140, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 140, 1'b0);
		run_phase(16'd0, 16'd0, 140, 1'b0);
		run_phase(DATA_W'($urandom_range(0, 65535)), DATA_W'($urandom_range(0, 400)), 140,
			1'b0);
		run_phase(DATA_W'($urandom_range(0, 65535)), DATA_W'($urandom_range(0, 65535)), 140,
			1'b0);
		run_phase(VALID_MAX_RESET, JUMP_THR_RESET, 140, 1'b1);

		wait_drained();
		if (expected_filtered.size() != 0)
			note_failure($sformatf("%0d expected words never arrived",
				expected_filtered.size()));
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== two_axis_spike_limit_and_average.f =====
design/tsa_pkg.sv
design/tsa_if.sv
design/tsa_alu.sv
design/tsa_ring.sv
design/two_axis_spike_limit_and_average.sv
design/tsa_checker.sv
tb/two_axis_spike_limit_and_average_tb.sv
